>>> design/dht_pkg.sv
// ----------------------------------------------------------------------------
// dht_pkg
// Shared types, register indexes, reset values and status codes of the
// single-wire humidity/temperature sensor reader.
// ----------------------------------------------------------------------------
package dht_pkg;

   // bits in one sensor frame: two response phases are followed by this many bits
   localparam int FRAME_BITS = 40;
   localparam int BIT_IDX_W  = $clog2(FRAME_BITS + 1);

   localparam int TICK_W     = 16;
   localparam int WAIT_W     = 8;
   localparam int TIMEOUT_W  = 8;
   localparam int SLACK_W    = 7;
   localparam int BYTE_W     = 8;
   localparam int STATUS_W   = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_START_LOW     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RELEASE_WAIT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT       = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RESPONSE_SLACK = 2'd3;

   // register reset values
   localparam logic [TICK_W-1:0]    START_LOW_RESET     = 16'd20000;
   localparam logic [WAIT_W-1:0]    RELEASE_WAIT_RESET  = 8'd10;
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET       = 8'd255;
   localparam logic [SLACK_W-1:0]   RESPONSE_SLACK_RESET = 7'd5;

   // reading status codes
   localparam logic [STATUS_W-1:0] STATUS_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_BAD_RESP  = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_LEVEL = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_TIMEOUT   = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_CHECKSUM  = 3'd4;

   // input item commands
   localparam logic CMD_TICK  = 1'b0;
   localparam logic CMD_START = 1'b1;

   typedef struct packed {
      logic command;
      logic line_level;
   } req_type;

   typedef struct packed {
      logic                drive_low;
      logic                busy_res;
      logic                done_res;
      logic [STATUS_W-1:0] status;
      logic [BYTE_W-1:0]   humidity;
      logic [BYTE_W-1:0]   temperature;
   } rsp_type;

   typedef struct packed {
      logic [TICK_W-1:0]    start_low_ticks;
      logic [WAIT_W-1:0]    release_wait_ticks;
      logic [TIMEOUT_W-1:0] timeout_ticks;
      logic [SLACK_W-1:0]   response_slack;
   } cfg_type;

endpackage

>>> design/dht_csr.sv
// ----------------------------------------------------------------------------
// dht_csr
// Configuration registers of the sensor reader, written through a
// valid/ready port by register index.
// ----------------------------------------------------------------------------
module dht_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [dht_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [dht_pkg::CSR_DATA_W-1:0]   csr_data,
   output dht_pkg::cfg_type                 cfg
);

   dht_pkg::cfg_type cfg_ff;
   dht_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            dht_pkg::CSR_START_LOW:
               cfg_in.start_low_ticks = csr_data;
            dht_pkg::CSR_RELEASE_WAIT:
               cfg_in.release_wait_ticks = csr_data[dht_pkg::WAIT_W-1:0];
            dht_pkg::CSR_TIMEOUT:
               cfg_in.timeout_ticks = csr_data[dht_pkg::TIMEOUT_W-1:0];
            dht_pkg::CSR_RESPONSE_SLACK:
               cfg_in.response_slack = csr_data[dht_pkg::SLACK_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_low_ticks    <= dht_pkg::START_LOW_RESET;
         cfg_ff.release_wait_ticks <= dht_pkg::RELEASE_WAIT_RESET;
         cfg_ff.timeout_ticks      <= dht_pkg::TIMEOUT_RESET;
         cfg_ff.response_slack     <= dht_pkg::RESPONSE_SLACK_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> design/dht_core.sv
// ----------------------------------------------------------------------------
// dht_core
// Reading sequencer: start pulse, release wait, response timing and
// frame bit decoding, one tick per transfer.
// ----------------------------------------------------------------------------
module dht_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              item_valid,
   input  dht_pkg::req_type  item,
   input  dht_pkg::cfg_type  cfg,
   output dht_pkg::rsp_type  result
);

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_START,
      PH_WAIT,
      PH_RESP1,
      PH_RESP2,
      PH_BITLOW,
      PH_BITHIGH
   } phase_type;

   localparam int TW = dht_pkg::TICK_W;
   localparam int BW = dht_pkg::BYTE_W;
   localparam int IW = dht_pkg::BIT_IDX_W;
   localparam logic [IW-1:0] FRAME_LAST = IW'(dht_pkg::FRAME_BITS);

   phase_type                    phase_ff, phase_in;
   logic [TW-1:0]                tick_ff, tick_in;
   logic [IW-1:0]                bit_index_ff, bit_index_in;
   logic                         seg_level_ff, seg_level_in;
   logic                         low_bad_ff, low_bad_in;
   logic [BW-1:0]                low_dur_ff, low_dur_in;
   logic [BW-1:0]                resp1_dur_ff, resp1_dur_in;
   logic [BW-1:0]                hum_ff, hum_in;
   logic [BW-1:0]                temp_ff, temp_in;
   logic [BW-1:0]                chk_ff, chk_in;
   logic [dht_pkg::STATUS_W-1:0] status_ff, status_in;
   logic                         done_in;

   logic [TW-1:0] tick_inc;
   logic          same_level;
   logic          seg_end;
   logic [BW-1:0] seg_dur;
   logic [BW:0]   resp_limit;
   logic [BW-1:0] bit_mask;
   logic [BW-1:0] sum8;

   // segment timing shared by the response and bit phases
   assign tick_inc   = tick_ff + TW'(1);
   assign same_level = (item.line_level == seg_level_ff);
   assign seg_end    = !same_level ||
                       !(tick_inc < {{(TW-dht_pkg::TIMEOUT_W){1'b0}}, cfg.timeout_ticks});
   // segment counts stay below the timeout, so the halved count fits a byte
   assign seg_dur    = same_level ? cfg.timeout_ticks : tick_ff[BW:1];
   assign resp_limit = {1'b0, resp1_dur_ff} + {{(BW+1-dht_pkg::SLACK_W){1'b0}},
                                               cfg.response_slack};
   assign bit_mask   = BW'(8'h80) >> bit_index_ff[2:0];

   always_comb begin
      phase_in     = phase_ff;
      tick_in      = tick_ff;
      bit_index_in = bit_index_ff;
      seg_level_in = seg_level_ff;
      low_bad_in   = low_bad_ff;
      low_dur_in   = low_dur_ff;
      resp1_dur_in = resp1_dur_ff;
      hum_in       = hum_ff;
      temp_in      = temp_ff;
      chk_in       = chk_ff;
      status_in    = status_ff;
      done_in      = 1'b0;
      sum8         = '0;

      if (item.command == dht_pkg::CMD_START) begin
         // a start during a reading is dropped
         if (phase_ff == PH_IDLE) begin
            hum_in       = '0;
            temp_in      = '0;
            chk_in       = '0;
            bit_index_in = '0;
            tick_in      = '0;
            low_bad_in   = 1'b0;
            phase_in     = PH_START;
         end
      end else begin
         unique case (phase_ff)
            PH_START: begin
               tick_in = tick_inc;
               if (tick_inc >= cfg.start_low_ticks) begin
                  tick_in  = '0;
                  phase_in = PH_WAIT;
               end
            end
            PH_WAIT: begin
               tick_in = tick_inc;
               if (tick_inc >= {{(TW-dht_pkg::WAIT_W){1'b0}}, cfg.release_wait_ticks}) begin
                  tick_in      = '0;
                  seg_level_in = item.line_level;
                  phase_in     = PH_RESP1;
               end
            end
            PH_RESP1, PH_RESP2, PH_BITLOW, PH_BITHIGH: begin
               if (!seg_end) begin
                  tick_in = tick_inc;
               end else begin
                  tick_in      = '0;
                  seg_level_in = item.line_level;
                  unique case (phase_ff)
                     PH_RESP1: begin
                        resp1_dur_in = seg_dur;
                        phase_in     = PH_RESP2;
                     end
                     PH_RESP2: begin
                        if (resp1_dur_ff != cfg.timeout_ticks &&
                            {1'b0, seg_dur} > resp_limit) begin
                           status_in = dht_pkg::STATUS_BAD_RESP;
                           phase_in  = PH_IDLE;
                           done_in   = 1'b1;
                        end else begin
                           bit_index_in = '0;
                           phase_in     = PH_BITLOW;
                        end
                     end
                     PH_BITLOW: begin
                        low_bad_in = seg_level_ff;
                        low_dur_in = seg_dur;
                        phase_in   = PH_BITHIGH;
                     end
                     default: begin
                        // high half of a bit pair
                        priority if (low_bad_ff || !seg_level_ff) begin
                           status_in = dht_pkg::STATUS_BAD_LEVEL;
                           phase_in  = PH_IDLE;
                           done_in   = 1'b1;
                        end else if (low_dur_ff == cfg.timeout_ticks ||
                                     seg_dur == cfg.timeout_ticks) begin
                           status_in = dht_pkg::STATUS_TIMEOUT;
                           phase_in  = PH_IDLE;
                           done_in   = 1'b1;
                        end else begin
                           if (low_dur_ff < seg_dur) begin
                              unique case (bit_index_ff[IW-1:3])
                                 3'd0:    hum_in  = hum_ff | bit_mask;
                                 3'd2:    temp_in = temp_ff | bit_mask;
                                 3'd4:    chk_in  = chk_ff | bit_mask;
                                 default: ;
                              endcase
                           end
                           bit_index_in = bit_index_ff + IW'(1);
                           if (bit_index_in >= FRAME_LAST) begin
                              sum8      = hum_in + temp_in;
                              status_in = (sum8 == chk_in) ? dht_pkg::STATUS_OK
                                                           : dht_pkg::STATUS_CHECKSUM;
                              phase_in  = PH_IDLE;
                              done_in   = 1'b1;
                           end else begin
                              phase_in = PH_BITLOW;
                           end
                        end
                     end
                  endcase
               end
            end
            default: ;
         endcase
      end
   end

   assign result.drive_low   = (phase_in == PH_START);
   assign result.busy_res    = (phase_in != PH_IDLE);
   assign result.done_res    = done_in;
   assign result.status      = status_in;
   assign result.humidity    = hum_in;
   assign result.temperature = temp_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         tick_ff      <= '0;
         bit_index_ff <= '0;
         seg_level_ff <= 1'b0;
         low_bad_ff   <= 1'b0;
         low_dur_ff   <= '0;
         resp1_dur_ff <= '0;
         hum_ff       <= '0;
         temp_ff      <= '0;
         chk_ff       <= '0;
         status_ff    <= dht_pkg::STATUS_OK;
      end else if (item_valid) begin
         phase_ff     <= phase_in;
         tick_ff      <= tick_in;
         bit_index_ff <= bit_index_in;
         seg_level_ff <= seg_level_in;
         low_bad_ff   <= low_bad_in;
         low_dur_ff   <= low_dur_in;
         resp1_dur_ff <= resp1_dur_in;
         hum_ff       <= hum_in;
         temp_ff      <= temp_in;
         chk_ff       <= chk_in;
         status_ff    <= status_in;
      end
   end

endmodule

>>> design/dht_out_buf.sv
// ----------------------------------------------------------------------------
// dht_out_buf
// Result register with a skid stage, so the input side can take one more
// transfer while a result waits on a stalled receiver.
// ----------------------------------------------------------------------------
module dht_out_buf (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  dht_pkg::rsp_type  in_data,
   output logic              full,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output dht_pkg::rsp_type  rsp_data
);

   logic             out_valid_ff, out_valid_in;
   dht_pkg::rsp_type out_data_ff, out_data_in;
   logic             skid_valid_ff, skid_valid_in;
   dht_pkg::rsp_type skid_data_ff, skid_data_in;
   logic             out_free;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign full      = skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      priority if (skid_valid_ff) begin
         // no new transfer while the skid stage holds a result
         if (out_free) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (in_valid) begin
         if (out_free) begin
            out_valid_in = 1'b1;
            out_data_in  = in_data;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = in_data;
         end
      end else if (out_free) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule

>>> design/dht11_single_wire_reader.sv
// ----------------------------------------------------------------------------
// dht11_single_wire_reader
// Single-wire humidity/temperature sensor reader driven by timer ticks.
// ----------------------------------------------------------------------------
// Each req_ transfer is either a start command or one timer tick carrying the
// sampled data-line level. Every req_ transfer yields exactly one rsp_
// transfer: drive_low (pull the line low), busy_res, done_res, the status of
// the last finished reading and the humidity/temperature bytes.
// The result of a req_ transfer is registered in the result register, or in
// the skid stage under rsp_stall. Throughput is one transfer per cycle while
// req_stall is low: the next state is formed by a single pass of logic from
// current state and the incoming item, into the state and result registers.
// A result register plus a skid stage sit on the rsp_ side; when rsp_stall
// holds a result, one more transfer is still taken and req_stall rises only
// once the skid stage is full.
// The csr_ port writes start_low_ticks, release_wait_ticks, timeout_ticks and
// response_slack by index 0..3; write it only while no reading is running.
// Synchronous reset returns the sequencer to idle, clears the bytes and
// status and loads the register defaults; nothing is pending after reset.
// ----------------------------------------------------------------------------
module dht11_single_wire_reader (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  dht_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output dht_pkg::rsp_type                rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [dht_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [dht_pkg::CSR_DATA_W-1:0]  csr_data
);

   dht_pkg::cfg_type cfg;
   dht_pkg::rsp_type core_result;
   logic             buf_full;
   logic             req_accept;

   assign req_stall  = buf_full;
   assign req_accept = req_valid && !buf_full;

   dht_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   dht_core u_core (
      .clock      (clock),
      .reset      (reset),
      .item_valid (req_accept),
      .item       (req_data),
      .cfg        (cfg),
      .result     (core_result)
   );

   dht_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_accept),
      .in_data   (core_result),
      .full      (buf_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

`ifndef ASSERT_OFF
   // skid stage only fills behind an occupied result register
   assert property (@(posedge clock) disable iff (reset) req_stall |-> rsp_valid)
      else $error("skid stage full while result register empty");

   // start pulse only inside a reading
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.drive_low |-> rsp_data.busy_res)
      else $error("drive_low outside a reading");

   // the finishing tick leaves the sequencer idle
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.done_res |-> !rsp_data.busy_res && !rsp_data.drive_low)
      else $error("reading finished but still busy");

   // status is one of the defined codes
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.status <= dht_pkg::STATUS_CHECKSUM)
      else $error("undefined status code");
`endif

endmodule

>>> test/tb_dht11_single_wire_reader.sv
// ----------------------------------------------------------------------------
// tb_dht11_single_wire_reader
// Self-checking testbench of the single-wire sensor reader.
// ----------------------------------------------------------------------------
// Sensor frames are played into the block one timer tick per req_ transfer:
// start pulse, response phases and 40 low/high bit pairs, clean or with an
// injected fault (overlong segment, level glitch, start while busy, cut-off
// frame), mixed with random noise. A tick-accurate model of the sequencer
// forms the expected result of every accepted transfer, and each rsp_
// transfer is compared field by field in order. Long start pulses (the reset
// default and the register maximum) are checked over their first ticks and
// then cut short by a reset. Directed readings cover the register extremes
// and every status code but the checksum error; random phases run under
// varied sender idling and receiver stalls, plus one long receiver hold-off
// that backs the block up into its input.
// ----------------------------------------------------------------------------
module tb_dht11_single_wire_reader;

   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int TOTAL_ITEMS     = 1850;
   localparam int MIN_PHASE_ITEMS = 60;
   localparam int PULSE_CHECK     = 40;
   localparam int FRAME_SEGS      = 2 + 2 * dht_pkg::FRAME_BITS;

   typedef enum logic [2:0] {
      RD_IDLE, RD_START, RD_WAIT, RD_RESP1, RD_RESP2, RD_BIT_LOW, RD_BIT_HIGH
   } rd_phase_type;

   typedef enum int {
      FAULT_NONE, FAULT_LONG, FAULT_GLITCH, FAULT_START, FAULT_CUT
   } fault_type;

   logic                           clock     = 1'b0;
   logic                           reset     = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   dht_pkg::req_type               req_data  = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   dht_pkg::rsp_type               rsp_data;
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic [dht_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [dht_pkg::CSR_DATA_W-1:0] csr_data  = '0;

   // sequencer model state
   dht_pkg::cfg_type rd_cfg;
   rd_phase_type     rd_phase;
   logic [15:0]      rd_ticks;
   logic [5:0]       rd_bit;
   logic             rd_seg_level;
   logic             rd_low_bad;
   logic             rd_done;
   logic [7:0]       rd_low_dur;
   logic [7:0]       rd_resp1_dur;
   logic [7:0]       rd_hum;
   logic [7:0]       rd_temp;
   logic [7:0]       rd_sum;
   logic [2:0]       rd_status;

   dht_pkg::rsp_type expected_rsp_q[$];
   int      fail_count    = 0;
   int      items_sent    = 0;
   int      quiet_cycles  = 0;
   int      send_idle_pct = 0;
   int      stall_pct     = 0;
   int      hold_request  = 0;

   always #5 clock = ~clock;

   dht11_single_wire_reader u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // ------------------------------------------------------------------------
   // sequencer model
   // ------------------------------------------------------------------------
   function automatic void reader_reset();
      rd_cfg.start_low_ticks    = dht_pkg::START_LOW_RESET;
      rd_cfg.release_wait_ticks = dht_pkg::RELEASE_WAIT_RESET;
      rd_cfg.timeout_ticks      = dht_pkg::TIMEOUT_RESET;
      rd_cfg.response_slack     = dht_pkg::RESPONSE_SLACK_RESET;
      rd_phase     = RD_IDLE;
      rd_ticks     = '0;
      rd_bit       = '0;
      rd_seg_level = 1'b0;
      rd_low_bad   = 1'b0;
      rd_done      = 1'b0;
      rd_low_dur   = '0;
      rd_resp1_dur = '0;
      rd_hum       = '0;
      rd_temp      = '0;
      rd_sum       = '0;
      rd_status    = dht_pkg::STATUS_OK;
   endfunction

   // times one level segment, returns 1 when it ends by a change or a timeout
   function automatic logic segment_end(input logic lvl, output logic [7:0] dur,
                                        output logic lev);
      dur = '0;
      lev = rd_seg_level;
      if (lvl == rd_seg_level) begin
         rd_ticks = rd_ticks + 16'd1;
         if (rd_ticks < 16'(rd_cfg.timeout_ticks))
            return 1'b0;
         dur = rd_cfg.timeout_ticks;
      end else begin
         dur = 8'(rd_ticks >> 1);
      end
      rd_seg_level = lvl;
      rd_ticks     = '0;
      return 1'b1;
   endfunction

   function automatic void end_reading(input logic [2:0] st);
      rd_status = st;
      rd_phase  = RD_IDLE;
      rd_ticks  = '0;
      rd_done   = 1'b1;
   endfunction

   function automatic dht_pkg::rsp_type reader_step(input dht_pkg::req_type item);
      dht_pkg::rsp_type r;
      logic [7:0]       dur;
      logic             lev;
      logic [7:0]       mask;
      logic [7:0]       sum8;
      rd_done = 1'b0;
      if (item.command == dht_pkg::CMD_START) begin
         // a start while busy is dropped
         if (rd_phase == RD_IDLE) begin
            rd_hum     = '0;
            rd_temp    = '0;
            rd_sum     = '0;
            rd_bit     = '0;
            rd_ticks   = '0;
            rd_low_bad = 1'b0;
            rd_phase   = RD_START;
         end
      end else begin
         case (rd_phase)
            RD_START: begin
               rd_ticks = rd_ticks + 16'd1;
               if (rd_ticks >= rd_cfg.start_low_ticks) begin
                  rd_ticks = '0;
                  rd_phase = RD_WAIT;
               end
            end
            RD_WAIT: begin
               rd_ticks = rd_ticks + 16'd1;
               if (rd_ticks >= 16'(rd_cfg.release_wait_ticks)) begin
                  rd_ticks     = '0;
                  rd_seg_level = item.line_level;
                  rd_phase     = RD_RESP1;
               end
            end
            RD_RESP1: begin
               if (segment_end(item.line_level, dur, lev)) begin
                  rd_resp1_dur = dur;
                  rd_phase     = RD_RESP2;
               end
            end
            RD_RESP2: begin
               if (segment_end(item.line_level, dur, lev)) begin
                  if (rd_resp1_dur != rd_cfg.timeout_ticks &&
                      int'(dur) > int'(rd_resp1_dur) + int'(rd_cfg.response_slack)) begin
                     end_reading(dht_pkg::STATUS_BAD_RESP);
                  end else begin
                     rd_bit   = '0;
                     rd_phase = RD_BIT_LOW;
                  end
               end
            end
            RD_BIT_LOW: begin
               if (segment_end(item.line_level, dur, lev)) begin
                  rd_low_bad = lev;
                  rd_low_dur = dur;
                  rd_phase   = RD_BIT_HIGH;
               end
            end
            RD_BIT_HIGH: begin
               if (segment_end(item.line_level, dur, lev)) begin
                  if (rd_low_bad || !lev) begin
                     end_reading(dht_pkg::STATUS_BAD_LEVEL);
                  end else if (rd_low_dur == rd_cfg.timeout_ticks ||
                               dur == rd_cfg.timeout_ticks) begin
                     end_reading(dht_pkg::STATUS_TIMEOUT);
                  end else begin
                     mask = 8'h80 >> rd_bit[2:0];
                     if (rd_low_dur < dur) begin
                        // bytes 1 and 3 are dropped
                        case (rd_bit[5:3])
                           3'd0: rd_hum  = rd_hum | mask;
                           3'd2: rd_temp = rd_temp | mask;
                           3'd4: rd_sum  = rd_sum | mask;
                           default: ;
                        endcase
                     end
                     rd_bit = rd_bit + 6'd1;
                     if (rd_bit >= dht_pkg::FRAME_BITS) begin
                        sum8 = rd_hum + rd_temp;
                        end_reading((sum8 == rd_sum) ? dht_pkg::STATUS_OK
                                                     : dht_pkg::STATUS_CHECKSUM);
                     end else begin
                        rd_phase = RD_BIT_LOW;
                     end
                  end
               end
            end
            default: rd_phase = RD_IDLE;
         endcase
      end
      r.drive_low   = (rd_phase == RD_START);
      r.busy_res    = (rd_phase != RD_IDLE);
      r.done_res    = rd_done;
      r.status      = rd_status;
      r.humidity    = rd_hum;
      r.temperature = rd_temp;
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // result checking, receiver stalls, watchdog
   // ------------------------------------------------------------------------
   task automatic check_field(input string name, input logic [7:0] exp_v,
                              input logic [7:0] act_v);
      if (exp_v != act_v) begin
         $error("%s: expected %0d, got %0d", name, exp_v, act_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : check_rsp
      dht_pkg::rsp_type exp_rsp;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsp_q.size() == 0) begin
            $error("result transfer with no expectation pending");
            fail_count++;
         end else begin
            exp_rsp = expected_rsp_q.pop_front();
            check_field("drive_low", 8'(exp_rsp.drive_low), 8'(rsp_data.drive_low));
            check_field("busy_res", 8'(exp_rsp.busy_res), 8'(rsp_data.busy_res));
            check_field("done_res", 8'(exp_rsp.done_res), 8'(rsp_data.done_res));
            check_field("status", 8'(exp_rsp.status), 8'(rsp_data.status));
            check_field("humidity", exp_rsp.humidity, rsp_data.humidity);
            check_field("temperature", exp_rsp.temperature, rsp_data.temperature);
         end
      end
   end

   // long hold-off first, otherwise random stalls
   always @(negedge clock) begin
      if (hold_request > 0) begin
         rsp_stall <= 1'b1;
         hold_request = hold_request - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("dht11_single_wire_reader verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------
   task automatic send_item(input logic cmd, input logic lvl);
      dht_pkg::req_type item;
      item.command    = cmd;
      item.line_level = lvl;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      forever begin
         @(posedge clock);
         if (!req_stall)
            break;
      end
      expected_rsp_q.push_back(reader_step(item));
      items_sent++;
   endtask

   // release the request channel and let every result transfer come back
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_rsp_q.size() != 0)
         @(posedge clock);
   endtask

   // abandon a long reading: drain, then reset the block and the model
   task automatic restart();
      wait_drained();
      @(negedge clock);
      reset <= 1'b1;
      repeat (2) @(posedge clock);
      reader_reset();
      @(negedge clock);
      reset <= 1'b0;
   endtask

   // a steady line makes any open segment time out, so this always ends
   task automatic finish_reading();
      while (rd_phase != RD_IDLE)
         send_item(dht_pkg::CMD_TICK, 1'b1);
   endtask

   task automatic csr_write(input logic [dht_pkg::CSR_IDX_W-1:0] idx,
                            input int unsigned value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= dht_pkg::CSR_DATA_W'(value);
      forever begin
         @(posedge clock);
         if (csr_ready)
            break;
      end
      case (idx)
         dht_pkg::CSR_START_LOW:
            rd_cfg.start_low_ticks    = dht_pkg::TICK_W'(value);
         dht_pkg::CSR_RELEASE_WAIT:
            rd_cfg.release_wait_ticks = dht_pkg::WAIT_W'(value);
         dht_pkg::CSR_TIMEOUT:
            rd_cfg.timeout_ticks      = dht_pkg::TIMEOUT_W'(value);
         dht_pkg::CSR_RESPONSE_SLACK:
            rd_cfg.response_slack     = dht_pkg::SLACK_W'(value);
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic apply_config(input int unsigned start_low, input int unsigned wait_ticks,
                               input int unsigned timeout, input int unsigned slack);
      finish_reading();
      wait_drained();
      csr_write(dht_pkg::CSR_START_LOW, start_low);
      csr_write(dht_pkg::CSR_RELEASE_WAIT, wait_ticks);
      csr_write(dht_pkg::CSR_TIMEOUT, timeout);
      csr_write(dht_pkg::CSR_RESPONSE_SLACK, slack);
   endtask

   // one level segment of halved duration d; extra is 0 when the segment's
   // first tick was already sent
   task automatic send_segment(input logic lvl, input int d, input int extra,
                               input fault_type fault);
      int t;
      int count;
      int len;
      int half;
      t     = rd_cfg.timeout_ticks;
      count = 2 * d + $urandom_range(1);
      if (t > 0 && count >= t)
         count = 2 * d;
      len = count + extra;
      if (fault == FAULT_LONG)
         len = t + 1 + $urandom_range(3);
      half = len / 2;
      if (fault == FAULT_GLITCH || fault == FAULT_START) begin
         repeat (half) send_item(dht_pkg::CMD_TICK, lvl);
         if (fault == FAULT_GLITCH)
            send_item(dht_pkg::CMD_TICK, !lvl);
         else
            send_item(dht_pkg::CMD_START, 1'($urandom_range(1)));
         len = len - half;
      end
      repeat (len) send_item(dht_pkg::CMD_TICK, lvl);
   endtask

   // one reading: start, pulse, response, 40 bits; negative d1/d2 or
   // fault_seg pick random values
   task automatic send_frame(input logic [7:0] hum, input logic [7:0] temp,
                             input logic [7:0] sum, input fault_type fault,
                             input int fault_seg, input int d1, input int d2);
      logic [39:0] frame;
      int          t;
      int          top;
      int          resp_max;
      int          bit_max;
      int          n_pre;
      int          seg;
      int          d;
      int          dl;
      int          dh;
      logic        one;
      t        = rd_cfg.timeout_ticks;
      top      = (t > 0) ? (t - 1) >> 1 : 0;
      resp_max = (top < 12) ? top : 12;
      bit_max  = (top < 1) ? top : 1;
      frame    = {hum, 8'($urandom), temp, 8'($urandom), sum};
      if (fault_seg < 0)
         fault_seg = $urandom_range(FRAME_SEGS - 1);
      if (d1 < 0)
         d1 = $urandom_range(resp_max);
      if (d2 < 0)
         d2 = $urandom_range(resp_max);
      dl = 0;
      dh = 0;
      send_item(dht_pkg::CMD_START, 1'($urandom_range(1)));
      // line held low through the pulse and the release wait
      n_pre = ((rd_cfg.start_low_ticks == 0) ? 1 : int'(rd_cfg.start_low_ticks)) +
              ((rd_cfg.release_wait_ticks == 0) ? 1 : int'(rd_cfg.release_wait_ticks));
      repeat (n_pre) send_item(dht_pkg::CMD_TICK, 1'b0);
      for (seg = 0; seg < FRAME_SEGS; seg++) begin
         if (fault == FAULT_CUT && seg == fault_seg)
            break;
         if (seg == 0) begin
            send_segment(1'b0, d1, 0, (seg == fault_seg) ? fault : FAULT_NONE);
         end else if (seg == 1) begin
            send_segment(1'b1, d2, 1, (seg == fault_seg) ? fault : FAULT_NONE);
         end else begin
            if (seg % 2 == 0) begin
               one = frame[39 - (seg - 2) / 2];
               if (one && bit_max > 0) begin
                  dl = $urandom_range(bit_max - 1);
                  dh = $urandom_range(bit_max, dl + 1);
               end else begin
                  dh = $urandom_range(bit_max);
                  dl = $urandom_range(bit_max, dh);
               end
               d = dl;
            end else begin
               d = dh;
            end
            send_segment(1'(seg % 2), d, 1, (seg == fault_seg) ? fault : FAULT_NONE);
         end
      end
      // falling edge that closes the last high segment
      send_item(dht_pkg::CMD_TICK, 1'b0);
      finish_reading();
   endtask

   task automatic send_noise(input int n);
      repeat (n) send_item(($urandom_range(9) == 0) ? dht_pkg::CMD_START
                                                    : dht_pkg::CMD_TICK,
                           1'($urandom_range(1)));
      finish_reading();
   endtask

   task automatic send_random_frame();
      logic [7:0] hum;
      logic [7:0] temp;
      logic [7:0] sum;
      int         pick;
      hum  = 8'($urandom);
      temp = 8'($urandom);
      sum  = ($urandom_range(9) == 0) ? 8'($urandom) : 8'(hum + temp);
      pick = $urandom_range(99);
      if (pick < 60)
         send_frame(hum, temp, sum, FAULT_NONE, -1, -1, -1);
      else if (pick < 90)
         send_frame(hum, temp, sum, fault_type'($urandom_range(FAULT_CUT, FAULT_LONG)),
                    -1, -1, -1);
      else
         send_noise($urandom_range(30, 5));
   endtask

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------
   // default pulse length: first ticks of the start pulse, then reset
   task automatic test_reset_defaults();
      send_item(dht_pkg::CMD_START, 1'b1);
      repeat (PULSE_CHECK) send_item(dht_pkg::CMD_TICK, 1'($urandom_range(1)));
      restart();
   endtask

   task automatic test_register_extremes();
      apply_config(1, 0, 1, 0);
      send_frame(8'h55, 8'hAA, 8'hFF, FAULT_NONE, -1, -1, -1);
      // register maximums, pulse cut short by a reset
      apply_config(65535, 255, 255, 127);
      send_item(dht_pkg::CMD_START, 1'b0);
      repeat (PULSE_CHECK) send_item(dht_pkg::CMD_TICK, 1'($urandom_range(1)));
      restart();
      // zero pulse length and zero timeout
      apply_config(0, 0, 0, 0);
      send_frame(8'h81, 8'h18, 8'h99, FAULT_NONE, -1, 0, 0);
   endtask

   task automatic test_status_codes();
      apply_config(4, 2, 16, 3);
      send_frame(8'hFF, 8'h01, 8'h00, FAULT_NONE, -1, 7, 0);
      // second response phase right at and just over the slack
      send_frame(8'h40, 8'h02, 8'h42, FAULT_NONE, -1, 2, 5);
      send_frame(8'h40, 8'h02, 8'h42, FAULT_NONE, -1, 2, 6);
      // first response phase timed out skips the response check
      send_frame(8'h11, 8'h22, 8'h33, FAULT_LONG, 0, 0, 0);
      send_frame(8'h11, 8'h22, 8'h33, FAULT_GLITCH, 20, 2, 2);
      send_frame(8'h11, 8'h22, 8'h33, FAULT_LONG, 30, 2, 2);
      send_frame(8'h7F, 8'h80, 8'hFF, FAULT_START, 50, 2, 2);
      send_frame(8'h11, 8'h22, 8'h33, FAULT_CUT, 33, 2, 2);
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      stall_pct     = 0;
      hold_request  = 60;
      send_noise(100);
   endtask

   task automatic test_random_phase(input int send_pct, input int rsp_pct,
                                    input int phase_end);
      apply_config($urandom_range(12, 1), $urandom_range(6), $urandom_range(14, 3),
                   $urandom_range(6));
      send_idle_pct = send_pct;
      stall_pct     = rsp_pct;
      do
         send_random_frame();
      while (items_sent < phase_end);
   endtask

   initial begin
      int random_base;
      int random_share;
      reader_reset();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_register_extremes();
      test_status_codes();
      test_backpressure();

      // the random phases share what is left of the item budget
      random_base  = items_sent;
      random_share = (TOTAL_ITEMS - random_base) / 4;
      if (random_share < MIN_PHASE_ITEMS)
         random_share = MIN_PHASE_ITEMS;
      test_random_phase(0, 0, random_base + random_share);
      test_random_phase(72, 0, random_base + 2 * random_share);
      test_random_phase(0, 72, random_base + 3 * random_share);
      test_random_phase(38, 38, random_base + 4 * random_share);

      finish_reading();
      wait_drained();
      stall_pct = 0;
      repeat (4) @(posedge clock);
      if (fail_count == 0)
         $display("dht11_single_wire_reader verification clean");
      else
         $display("dht11_single_wire_reader verification failed");
      $finish;
   end

endmodule
